FILE: rtl/core/wrp_pkg.sv
`timescale 1ns / 1ps

package wrp_pkg;

	localparam int FIELD_SLOTS = 5;
	localparam int ID_W = 8;
	localparam int WEIGHT_W = 7;
	localparam int RAND_W = 32;
	localparam int COUNT_W = 3;
	// Widest possible sum of all drawing weights.
	localparam int SUM_W = $clog2(FIELD_SLOTS * (2 ** WEIGHT_W - 1) + 1);
	localparam int BITS_PER_STAGE = 4;
	localparam int MOD_STAGES = RAND_W / BITS_PER_STAGE;

	localparam logic [WEIGHT_W-1:0] ALWAYS_WEIGHT = WEIGHT_W'(100);

	typedef struct packed {
		logic signed [ID_W-1:0] id;
		logic                   is_fixed;
		logic                   draw;
		logic [WEIGHT_W-1:0]    weight;
	} lane_info_t;

	typedef struct packed {
		lane_info_t [FIELD_SLOTS-1:0]            slot;
		logic [FIELD_SLOTS-1:0][SUM_W-1:0]       run;
		logic                                    any_draw;
		logic                                    zero_total;
	} pick_data_t;

endpackage

FILE: rtl/core/wrp_lane.sv
`timescale 1ns / 1ps

module wrp_lane (
	input  logic                                 clk,
	input  logic signed [wrp_pkg::ID_W-1:0]      slot_id,
	input  logic [wrp_pkg::WEIGHT_W-1:0]         slot_weight,
	output wrp_pkg::lane_info_t                  info_s1
);

	logic nonempty;
	logic fixed;

	assign nonempty = (slot_id != '0);
	assign fixed = nonempty && (slot_weight == wrp_pkg::ALWAYS_WEIGHT);

	always_ff @(posedge clk) begin
		info_s1.id <= slot_id;
		info_s1.is_fixed <= fixed;
		info_s1.draw <= nonempty && !fixed;
		// A slot that does not take part in the draw adds nothing to the running sums.
		info_s1.weight <= (nonempty && !fixed) ? slot_weight : '0;
	end

endmodule

FILE: rtl/core/wrp_mod.sv
`timescale 1ns / 1ps

module wrp_mod (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [wrp_pkg::RAND_W-1:0]        dividend,
	input  logic [wrp_pkg::SUM_W-1:0]         divisor,
	output logic                              out_valid,
	output logic [wrp_pkg::SUM_W-1:0]         remainder
);

	localparam int SW = wrp_pkg::SUM_W;
	localparam int RW = wrp_pkg::RAND_W;
	localparam int BPS = wrp_pkg::BITS_PER_STAGE;
	localparam int NST = wrp_pkg::MOD_STAGES;

	logic [SW-1:0] rem_q [NST];
	logic [RW-1:0] num_q [NST];
	logic [SW-1:0] div_q [NST];
	logic          vld_q [NST];

	for (genvar s = 0; s < NST; s++) begin : g_stage
		logic [SW-1:0] rem_in;
		logic [RW-1:0] num_in;
		logic [SW-1:0] div_in;
		logic          vld_in;
		logic [SW-1:0] rem_nx;

		if (s == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = dividend;
			assign div_in = divisor;
			assign vld_in = in_valid;
		end else begin : g_next
			assign rem_in = rem_q[s-1];
			assign num_in = num_q[s-1];
			assign div_in = div_q[s-1];
			assign vld_in = vld_q[s-1];
		end

		// Restoring remainder steps, most significant dividend bit first.
		always_comb begin
			logic [SW:0]   t;
			logic [SW-1:0] r;
			r = rem_in;
			t = '0;
			for (int b = 0; b < BPS; b++) begin
				t = {r, num_in[RW-1-b]};
				if (t >= {1'b0, div_in}) begin
					t = t - {1'b0, div_in};
				end
				r = t[SW-1:0];
			end
			rem_nx = r;
		end

		always_ff @(posedge clk) begin
			rem_q[s] <= rem_nx;
			num_q[s] <= num_in << BPS;
			div_q[s] <= div_in;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[s] <= 1'b0;
			end else begin
				vld_q[s] <= vld_in;
			end
		end
	end

	assign out_valid = vld_q[NST-1];
	assign remainder = rem_q[NST-1];

endmodule

FILE: rtl/core/wrp_merge.sv
`timescale 1ns / 1ps

module wrp_merge (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  in_valid,
	input  wrp_pkg::pick_data_t                                   data,
	input  logic [wrp_pkg::SUM_W-1:0]                             roll,
	output logic                                                  done,
	output logic [wrp_pkg::FIELD_SLOTS-1:0][wrp_pkg::ID_W-1:0]    chosen_q,
	output logic [wrp_pkg::COUNT_W-1:0]                           count_q,
	output logic                                                  flag_q
);

	localparam int NS = wrp_pkg::FIELD_SLOTS;
	localparam int CW = wrp_pkg::COUNT_W;

	logic [NS-1:0][wrp_pkg::ID_W-1:0] chosen_nx;
	logic [CW-1:0]                    count_nx;
	logic                             flag_nx;

	always_comb begin
		logic [CW-1:0]              n;
		logic                       found;
		logic [wrp_pkg::ID_W-1:0]   pick;
		n = '0;
		found = 1'b0;
		pick = '0;
		chosen_nx = '0;
		// Fixed slots go first, packed in slot order.
		for (int i = 0; i < NS; i++) begin
			if (data.slot[i].is_fixed && (n < CW'(NS))) begin
				chosen_nx[n] = data.slot[i].id;
				n = n + 1'b1;
			end
		end
		// The first drawing slot whose running sum exceeds the roll wins.
		for (int i = 0; i < NS; i++) begin
			if (!found && data.slot[i].draw && (roll < data.run[i])) begin
				found = 1'b1;
				pick = data.slot[i].id;
			end
		end
		if (data.any_draw && !data.zero_total && found && (n < CW'(NS))) begin
			chosen_nx[n] = pick;
			n = n + 1'b1;
		end
		count_nx = n;
		flag_nx = data.any_draw && data.zero_total;
	end

	always_ff @(posedge clk) begin
		chosen_q <= chosen_nx;
		count_q <= count_nx;
		flag_q <= flag_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= in_valid;
		end
	end

endmodule

FILE: rtl/core/weighted_random_pick_top.sv
`timescale 1ns / 1ps

// Pipeline: a request passes through the slot lanes, the prefix sums, eight remainder stages
// of four bits each and the merge; done and the result are registered together in the merge.
// Throughput: one request per cycle; busy stays low and the receiver cannot stall.
// Reset: arst_n clears every valid bit in the pipeline at once; no request is lost to it
// once it is released, and no done pulse appears while it is held.
module weighted_random_pick_top #(
	parameter int SLOT_COUNT = 5
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [wrp_pkg::ID_W-1:0]        slot_id_a,
	input  logic signed [wrp_pkg::ID_W-1:0]        slot_id_b,
	input  logic signed [wrp_pkg::ID_W-1:0]        slot_id_c,
	input  logic signed [wrp_pkg::ID_W-1:0]        slot_id_d,
	input  logic signed [wrp_pkg::ID_W-1:0]        slot_id_e,
	input  logic [wrp_pkg::WEIGHT_W-1:0]           slot_weight_a,
	input  logic [wrp_pkg::WEIGHT_W-1:0]           slot_weight_b,
	input  logic [wrp_pkg::WEIGHT_W-1:0]           slot_weight_c,
	input  logic [wrp_pkg::WEIGHT_W-1:0]           slot_weight_d,
	input  logic [wrp_pkg::WEIGHT_W-1:0]           slot_weight_e,
	input  logic [wrp_pkg::RAND_W-1:0]             random_word,
	output logic                                   done,
	output logic signed [wrp_pkg::ID_W-1:0]        chosen_a,
	output logic signed [wrp_pkg::ID_W-1:0]        chosen_b,
	output logic signed [wrp_pkg::ID_W-1:0]        chosen_c,
	output logic signed [wrp_pkg::ID_W-1:0]        chosen_d,
	output logic signed [wrp_pkg::ID_W-1:0]        chosen_e,
	output logic [wrp_pkg::COUNT_W-1:0]            chosen_count,
	output logic                                   zero_total_flag
);

	localparam int NS = wrp_pkg::FIELD_SLOTS;
	localparam int SW = wrp_pkg::SUM_W;
	localparam int NST = wrp_pkg::MOD_STAGES;
	localparam int LANES = (SLOT_COUNT < NS) ? SLOT_COUNT : NS;

	logic signed [wrp_pkg::ID_W-1:0]  id_in [NS];
	logic [wrp_pkg::WEIGHT_W-1:0]     wt_in [NS];
	wrp_pkg::lane_info_t              info_s1 [NS];
	logic                             valid_s1;
	logic [wrp_pkg::RAND_W-1:0]       random_s1;

	wrp_pkg::pick_data_t              data_nx;
	logic [SW-1:0]                    total_nx;
	wrp_pkg::pick_data_t              data_s2;
	logic [SW-1:0]                    total_s2;
	logic                             valid_s2;
	logic [wrp_pkg::RAND_W-1:0]       random_s2;

	wrp_pkg::pick_data_t              data_dly_q [NST];
	logic                             mod_valid;
	logic [SW-1:0]                    roll;
	logic [NS-1:0][wrp_pkg::ID_W-1:0] chosen_q;

	// Every stage moves on each cycle, so a request is always taken.
	assign busy = 1'b0;

	assign id_in[0] = slot_id_a;
	assign id_in[1] = slot_id_b;
	assign id_in[2] = slot_id_c;
	assign id_in[3] = slot_id_d;
	assign id_in[4] = slot_id_e;
	assign wt_in[0] = slot_weight_a;
	assign wt_in[1] = slot_weight_b;
	assign wt_in[2] = slot_weight_c;
	assign wt_in[3] = slot_weight_d;
	assign wt_in[4] = slot_weight_e;

	for (genvar i = 0; i < NS; i++) begin : g_lane
		if (i < LANES) begin : g_active
			wrp_lane u_lane (
				.clk         (clk),
				.slot_id     (id_in[i]),
				.slot_weight (wt_in[i]),
				.info_s1     (info_s1[i])
			);
		end else begin : g_idle
			// Slots past the configured count behave as empty.
			assign info_s1[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		random_s1 <= random_word;
	end

	always_comb begin
		logic [SW-1:0] acc;
		logic          any;
		acc = '0;
		any = 1'b0;
		data_nx = '0;
		for (int i = 0; i < NS; i++) begin
			data_nx.slot[i] = info_s1[i];
			acc = acc + SW'(info_s1[i].weight);
			data_nx.run[i] = acc;
			any = any | info_s1[i].draw;
		end
		data_nx.any_draw = any;
		data_nx.zero_total = (acc == '0);
		total_nx = acc;
	end

	always_ff @(posedge clk) begin
		data_s2 <= data_nx;
		total_s2 <= total_nx;
		random_s2 <= random_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	wrp_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.dividend  (random_s2),
		.divisor   (total_s2),
		.out_valid (mod_valid),
		.remainder (roll)
	);

	// The slot data rides alongside the remainder stages.
	always_ff @(posedge clk) begin
		data_dly_q[0] <= data_s2;
		for (int k = 1; k < NST; k++) begin
			data_dly_q[k] <= data_dly_q[k-1];
		end
	end

	wrp_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mod_valid),
		.data     (data_dly_q[NST-1]),
		.roll     (roll),
		.done     (done),
		.chosen_q (chosen_q),
		.count_q  (chosen_count),
		.flag_q   (zero_total_flag)
	);

	assign chosen_a = chosen_q[0];
	assign chosen_b = chosen_q[1];
	assign chosen_c = chosen_q[2];
	assign chosen_d = chosen_q[3];
	assign chosen_e = chosen_q[4];

endmodule
